// ===== sv/rgb_to_hsv_pixel_defines.svh =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_defines
// assertion macros shared by the rgb to hsv converter
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_PIXEL_DEFINES_SVH
`define RGB_TO_HSV_PIXEL_DEFINES_SVH

`ifndef SYNTH

`define RHSV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define RHSV_ASSERT_IMP(lbl, ante, cons, msg) \
  `RHSV_ASSERT(lbl, (ante) |-> (cons), msg)

`else

`define RHSV_ASSERT(lbl, prop, msg)

`define RHSV_ASSERT_IMP(lbl, ante, cons, msg)

`endif

`endif

// ===== sv/rhsv_pkg.sv =====
// ----------------------------------------------------------------------------
// rhsv_pkg
// widths, constants and stage payload types of the rgb to hsv converter
// ----------------------------------------------------------------------------
`default_nettype none

package rhsv_pkg;

  localparam int CH_W       = 8;
  localparam int HUE_FRAC   = 6;
  localparam int HUE_W      = 15;
  localparam int HUE_SECTOR = 60 << HUE_FRAC;
  localparam int HUE_CIRCLE = 360 << HUE_FRAC;
  localparam int CH_MAX     = (1 << CH_W) - 1;

  // quotient widths of the two divisions
  localparam int HUE_Q_W = $clog2(HUE_SECTOR + 1);
  localparam int SAT_Q_W = CH_W;

  localparam int NUM_HUE_W  = CH_W + HUE_Q_W;
  localparam int NUM_SAT_W  = CH_W + SAT_Q_W;
  localparam int DIV_STAGES = (HUE_Q_W > SAT_Q_W) ? HUE_Q_W : SAT_Q_W;

  // signed working width of the hue sum
  localparam int HUE_CALC_W = HUE_W + 2;

  typedef enum logic [2:0] {
    SECT_RED   = 3'b001,
    SECT_GREEN = 3'b010,
    SECT_BLUE  = 3'b100
  } sector_e;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  saturation;
    logic [CH_W-1:0]  brightness;
    logic             hue_undefined;
  } hsv_t;

  typedef struct packed {
    sector_e sector;
    logic    neg;
    logic    undef;
  } side_t;

  typedef struct packed {
    logic [NUM_HUE_W-1:0] hue_num;
    logic [CH_W-1:0]      hue_den;
    logic [NUM_SAT_W-1:0] sat_num;
    logic [CH_W-1:0]      sat_den;
    side_t                side;
  } div_req_t;

  typedef struct packed {
    logic [HUE_Q_W-1:0] hue_quo;
    logic               hue_rem_nz;
    logic [SAT_Q_W-1:0] sat_quo;
    logic [CH_W-1:0]    brightness;
    side_t              side;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== sv/rhsv_if.sv =====
// ----------------------------------------------------------------------------
// rhsv_if
// valid/ready channels carrying rgb pixels in and hsv pixels out
// ----------------------------------------------------------------------------
`default_nettype none

interface rhsv_rgb_if import rhsv_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface rhsv_hsv_if import rhsv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue;
  logic [CH_W-1:0]  saturation;
  logic [CH_W-1:0]  brightness;
  logic             hue_undefined;

  modport source (output valid, output hue, output saturation, output brightness,
                  output hue_undefined, input ready);
  modport sink (input valid, input hue, input saturation, input brightness,
                input hue_undefined, output ready);
endinterface

`default_nettype wire

// ===== sv/rhsv_front.sv =====
// ----------------------------------------------------------------------------
// rhsv_front
// two stages: max, min and hue sector, then the scaled dividends
// ----------------------------------------------------------------------------
`default_nettype none

module rhsv_front import rhsv_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  output logic          ready_o,
  input  wire rgb_t     pix_i,
  output logic          valid_o,
  input  wire logic     ready_i,
  output div_req_t      req_o
);

  logic                   en1, en2;
  logic                   v1_q, v2_q;
  logic [CH_W-1:0]        mx_d, mn_d, mx_q, delta_q;
  logic signed [CH_W:0]   diff_d, diff_q;
  sector_e                sector_d, sector_q;
  logic [CH_W:0]          ndiff;
  logic [CH_W-1:0]        absd;
  div_req_t               req_d, req_q;

  assign en2     = ~v2_q | ready_i;
  assign en1     = ~v1_q | en2;
  assign ready_o = en1;

  // stage 1: extremes and sector, red wins ties then green
  always_comb begin
    mx_d = pix_i.red;
    mn_d = pix_i.red;
    if (pix_i.green > mx_d) mx_d = pix_i.green;
    if (pix_i.blue > mx_d) mx_d = pix_i.blue;
    if (pix_i.green < mn_d) mn_d = pix_i.green;
    if (pix_i.blue < mn_d) mn_d = pix_i.blue;
    if (pix_i.red >= pix_i.green && pix_i.red >= pix_i.blue) begin
      sector_d = SECT_RED;
      diff_d   = {1'b0, pix_i.green} - {1'b0, pix_i.blue};
    end else if (pix_i.green >= pix_i.blue) begin
      sector_d = SECT_GREEN;
      diff_d   = {1'b0, pix_i.blue} - {1'b0, pix_i.red};
    end else begin
      sector_d = SECT_BLUE;
      diff_d   = {1'b0, pix_i.red} - {1'b0, pix_i.green};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      mx_q     <= mx_d;
      delta_q  <= mx_d - mn_d;
      diff_q   <= diff_d;
      sector_q <= sector_d;
    end
  end

  // stage 2: magnitude of the difference and constant scaling
  always_comb begin
    ndiff              = -diff_q;
    absd               = diff_q[CH_W] ? ndiff[CH_W-1:0] : diff_q[CH_W-1:0];
    req_d.hue_num      = NUM_HUE_W'(absd) * NUM_HUE_W'(HUE_SECTOR);
    req_d.hue_den      = delta_q;
    req_d.sat_num      = NUM_SAT_W'(delta_q) * NUM_SAT_W'(CH_MAX);
    req_d.sat_den      = mx_q;
    req_d.side.sector  = sector_q;
    req_d.side.neg     = diff_q[CH_W];
    req_d.side.undef   = (delta_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      req_q <= req_d;
    end
  end

  assign valid_o = v2_q;
  assign req_o   = req_q;

endmodule

`default_nettype wire

// ===== sv/rhsv_div.sv =====
// ----------------------------------------------------------------------------
// rhsv_div
// pipelined restoring dividers for hue and saturation, one quotient bit
// per stage
// ----------------------------------------------------------------------------
`default_nettype none

module rhsv_div import rhsv_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  output logic          ready_o,
  input  wire div_req_t req_i,
  output logic          valid_o,
  input  wire logic     ready_i,
  output div_rsp_t      rsp_o
);

  localparam int N = DIV_STAGES;

  // work words hold the partial remainder on top and dividend/quotient below
  logic [N:0]           en;
  logic                 v_q  [N];
  logic [NUM_HUE_W-1:0] hw_q [N];
  logic [CH_W-1:0]      hd_q [N];
  logic [NUM_SAT_W-1:0] sw_q [N];
  logic [CH_W-1:0]      sd_q [N];
  side_t                sb_q [N];

  assign en[N] = ready_i;

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic                 v_in;
    logic [NUM_HUE_W-1:0] hw_in, hw_d;
    logic [CH_W-1:0]      hd_in;
    logic [NUM_SAT_W-1:0] sw_in, sw_d;
    logic [CH_W-1:0]      sd_in;
    side_t                sb_in;

    if (s == 0) begin : g_first
      assign v_in  = valid_i;
      assign hw_in = req_i.hue_num;
      assign hd_in = req_i.hue_den;
      assign sw_in = req_i.sat_num;
      assign sd_in = req_i.sat_den;
      assign sb_in = req_i.side;
    end else begin : g_next
      assign v_in  = v_q[s-1];
      assign hw_in = hw_q[s-1];
      assign hd_in = hd_q[s-1];
      assign sw_in = sw_q[s-1];
      assign sd_in = sd_q[s-1];
      assign sb_in = sb_q[s-1];
    end

    if (s < HUE_Q_W) begin : g_hue
      logic [CH_W:0] ht, hsub;
      always_comb begin
        ht   = {hw_in[NUM_HUE_W-1 -: CH_W], hw_in[HUE_Q_W-1]};
        hsub = ht - {1'b0, hd_in};
        if (ht >= {1'b0, hd_in}) begin
          hw_d = {hsub[CH_W-1:0], hw_in[HUE_Q_W-2:0], 1'b1};
        end else begin
          hw_d = {ht[CH_W-1:0], hw_in[HUE_Q_W-2:0], 1'b0};
        end
      end
    end else begin : g_hue_hold
      assign hw_d = hw_in;
    end

    if (s < SAT_Q_W) begin : g_sat
      logic [CH_W:0] st, ssub;
      always_comb begin
        st   = {sw_in[NUM_SAT_W-1 -: CH_W], sw_in[SAT_Q_W-1]};
        ssub = st - {1'b0, sd_in};
        if (st >= {1'b0, sd_in}) begin
          sw_d = {ssub[CH_W-1:0], sw_in[SAT_Q_W-2:0], 1'b1};
        end else begin
          sw_d = {st[CH_W-1:0], sw_in[SAT_Q_W-2:0], 1'b0};
        end
      end
    end else begin : g_sat_hold
      assign sw_d = sw_in;
    end

    assign en[s] = ~v_q[s] | en[s+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en[s]) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[s]) begin
        hw_q[s] <= hw_d;
        hd_q[s] <= hd_in;
        sw_q[s] <= sw_d;
        sd_q[s] <= sd_in;
        sb_q[s] <= sb_in;
      end
    end
  end

  assign ready_o          = en[0];
  assign valid_o          = v_q[N-1];
  assign rsp_o.hue_quo    = hw_q[N-1][HUE_Q_W-1:0];
  assign rsp_o.hue_rem_nz = |hw_q[N-1][NUM_HUE_W-1 -: CH_W];
  assign rsp_o.sat_quo    = sw_q[N-1][SAT_Q_W-1:0];
  assign rsp_o.brightness = sd_q[N-1];
  assign rsp_o.side       = sb_q[N-1];

endmodule

`default_nettype wire

// ===== sv/rhsv_back.sv =====
// ----------------------------------------------------------------------------
// rhsv_back
// hue offset, floor correction, wrap and output register
// ----------------------------------------------------------------------------
`default_nettype none

module rhsv_back import rhsv_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  output logic          ready_o,
  input  wire div_rsp_t rsp_i,
  output logic          valid_o,
  input  wire logic     ready_i,
  output hsv_t          hsv_o
);

  logic                         en;
  logic                         v_q;
  logic signed [HUE_CALC_W-1:0] off, qx, rx, h;
  hsv_t                         hsv_d, hsv_q;

  assign en      = ~v_q | ready_i;
  assign ready_o = en;

  always_comb begin
    case (rsp_i.side.sector)
      SECT_RED:   off = '0;
      SECT_GREEN: off = HUE_CALC_W'(2 * HUE_SECTOR);
      SECT_BLUE:  off = HUE_CALC_W'(4 * HUE_SECTOR);
      default:    off = '0;
    endcase
    qx = HUE_CALC_W'(rsp_i.hue_quo);
    rx = HUE_CALC_W'(rsp_i.hue_rem_nz);
    // negative difference rounds toward minus infinity
    if (rsp_i.side.neg) begin
      h = off - qx - rx;
    end else begin
      h = off + qx;
    end
    if (h < 0) begin
      h = h + HUE_CALC_W'(HUE_CIRCLE);
    end
    hsv_d.hue           = rsp_i.side.undef ? '0 : h[HUE_W-1:0];
    hsv_d.saturation    = rsp_i.side.undef ? '0 : rsp_i.sat_quo;
    hsv_d.brightness    = rsp_i.brightness;
    hsv_d.hue_undefined = rsp_i.side.undef;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hsv_q <= hsv_d;
    end
  end

  assign valid_o = v_q;
  assign hsv_o   = hsv_q;

endmodule

`default_nettype wire

// ===== sv/rgb_to_hsv_pixel.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel
// fixed-point rgb to hsv pixel converter, top level
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output is not stalled and returns one
// hsv pixel per transaction, in order: two front stages find the max,
// min and hue sector, twelve stages of a restoring divider produce one hue
// quotient bit each (saturation is divided alongside in the first eight),
// and one stage adds the sector offset into the output register. Every stage
// holds its pixel while the next one is full, so bubbles close up and the
// input stays ready while the pipeline has room. Hue is in 1/64 degree
// (0 to 23039); gray pixels set hue_undefined and report hue and saturation 0.
`default_nettype none

`include "rgb_to_hsv_pixel_defines.svh"

module rgb_to_hsv_pixel import rhsv_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  rhsv_rgb_if.sink    rgb_i,
  rhsv_hsv_if.source  hsv_o
);

  rgb_t     pix;
  hsv_t     hsv;
  div_req_t req;
  div_rsp_t rsp;
  logic     req_valid, req_ready, rsp_valid, rsp_ready;

  assign pix.red   = rgb_i.red;
  assign pix.green = rgb_i.green;
  assign pix.blue  = rgb_i.blue;

  rhsv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rgb_i.valid),
    .ready_o (rgb_i.ready),
    .pix_i   (pix),
    .valid_o (req_valid),
    .ready_i (req_ready),
    .req_o   (req)
  );

  rhsv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req_valid),
    .ready_o (req_ready),
    .req_i   (req),
    .valid_o (rsp_valid),
    .ready_i (rsp_ready),
    .rsp_o   (rsp)
  );

  rhsv_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rsp_valid),
    .ready_o (rsp_ready),
    .rsp_i   (rsp),
    .valid_o (hsv_o.valid),
    .ready_i (hsv_o.ready),
    .hsv_o   (hsv)
  );

  assign hsv_o.hue           = hsv.hue;
  assign hsv_o.saturation    = hsv.saturation;
  assign hsv_o.brightness    = hsv.brightness;
  assign hsv_o.hue_undefined = hsv.hue_undefined;

  `RHSV_ASSERT_IMP(a_hue_range, hsv_o.valid, hsv_o.hue < HUE_W'(HUE_CIRCLE), "hue out of range")
  `RHSV_ASSERT_IMP(a_gray_hue, hsv_o.valid && hsv_o.hue_undefined, hsv_o.hue == '0 && hsv_o.saturation == '0, "gray pixel with hue or saturation")
  `RHSV_ASSERT_IMP(a_black, hsv_o.valid && hsv_o.brightness == '0, hsv_o.hue_undefined, "black pixel with defined hue")
  `RHSV_ASSERT_IMP(a_color_sat, hsv_o.valid && !hsv_o.hue_undefined, hsv_o.saturation != '0, "colored pixel with zero saturation")

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking testbench for the rgb to hsv pixel converter
// ----------------------------------------------------------------------------
// Drives rgb pixels into the converter with random source gaps and random sink
// stalls. Each accepted pixel is converted by an in-bench fixed-point model and
// queued. Every hsv transaction that comes out is compared field by field with
// the oldest queued pixel. Directed corners come first, then random pixels of
// several shapes: uniform, gray and tied channels, channels close together,
// back-to-back bursts and bursts that wait for the pipeline to empty.
`timescale 1ns / 100ps

module tb;
  import rhsv_pkg::*;

  localparam int CLK_PERIOD  = 12;
  localparam int CYCLE_LIMIT = 400000;
  localparam int FLUSH_WAIT  = 40;
  localparam int MAX_REPORTS = 10;

  logic clk;
  logic rst_n;

  rhsv_rgb_if rgb_if ();
  rhsv_hsv_if hsv_if ();

  rgb_to_hsv_pixel DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .rgb_i  (rgb_if),
    .hsv_o  (hsv_if)
  );

  hsv_t pending_hsv[$];
  int   mismatch_count;
  int   pixels_taken;
  int   gray_seen;
  int   wrapped_seen;
  int   cycle_count;
  bit   source_gaps;
  bit   sink_stalls;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // mostly short idle stretches, now and then a long one
  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic hsv_t predict_hsv(rgb_t px);
    int   r, g, b, mx, mn, delta, diff, offset, num, hue_val;
    hsv_t res;
    r = px.red;
    g = px.green;
    b = px.blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
    hue_val = 0;
    res.saturation = (mx != 0) ? CH_W'((delta * CH_MAX) / mx) : '0;
    res.brightness = CH_W'(mx);
    res.hue_undefined = (delta == 0);
    if (delta != 0) begin
      if (r == mx) begin
        diff = g - b;
        offset = 0;
      end else if (g == mx) begin
        diff = b - r;
        offset = 2 * HUE_SECTOR;
      end else begin
        diff = r - g;
        offset = 4 * HUE_SECTOR;
      end
      num = diff * HUE_SECTOR;
      // floor toward minus infinity
      if (num >= 0) hue_val = num / delta;
      else hue_val = -((-num + delta - 1) / delta);
      hue_val += offset;
      if (hue_val < 0) hue_val += HUE_CIRCLE;
    end
    res.hue = HUE_W'(hue_val);
    return res;
  endfunction

  function automatic void report_mismatch(hsv_t exp_px, hsv_t got_px);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t mismatch: expected hue %0d sat %0d val %0d undef %0b, got hue %0d sat %0d val %0d undef %0b",
               $time, exp_px.hue, exp_px.saturation, exp_px.brightness, exp_px.hue_undefined,
               got_px.hue, got_px.saturation, got_px.brightness, got_px.hue_undefined);
  endfunction

  // input side pushes predictions, output side checks against the oldest one
  always @(posedge clk) begin
    hsv_t exp_px;
    hsv_t got_px;
    rgb_t in_px;
    if (rst_n) begin
      if (rgb_if.valid && rgb_if.ready) begin
        in_px = '{red: rgb_if.red, green: rgb_if.green, blue: rgb_if.blue};
        exp_px = predict_hsv(in_px);
        pending_hsv.push_back(exp_px);
        pixels_taken++;
        if (exp_px.hue_undefined) gray_seen++;
        if (in_px.red >= in_px.green && in_px.red >= in_px.blue && in_px.green < in_px.blue)
          wrapped_seen++;
      end
      if (hsv_if.valid && hsv_if.ready) begin
        got_px.hue = hsv_if.hue;
        got_px.saturation = hsv_if.saturation;
        got_px.brightness = hsv_if.brightness;
        got_px.hue_undefined = hsv_if.hue_undefined;
        if (pending_hsv.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t unexpected hsv transaction: hue %0d sat %0d val %0d undef %0b",
                     $time, got_px.hue, got_px.saturation, got_px.brightness,
                     got_px.hue_undefined);
        end else begin
          exp_px = pending_hsv.pop_front();
          if (got_px.hue !== exp_px.hue || got_px.saturation !== exp_px.saturation ||
              got_px.brightness !== exp_px.brightness ||
              got_px.hue_undefined !== exp_px.hue_undefined)
            report_mismatch(exp_px, got_px);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_hsv.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : sink_ready
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (sink_stalls && $urandom_range(0, 3) == 0) begin
        hsv_if.ready <= 1'b0;
        repeat (idle_len()) @(negedge clk);
      end
      hsv_if.ready <= 1'b1;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_pixel(input rgb_t px);
    if (source_gaps && $urandom_range(0, 3) == 0) begin
      rgb_if.valid <= 1'b0;
      rgb_if.red   <= $urandom;
      rgb_if.green <= $urandom;
      rgb_if.blue  <= $urandom;
      repeat (idle_len()) @(negedge clk);
    end
    rgb_if.valid <= 1'b1;
    rgb_if.red   <= px.red;
    rgb_if.green <= px.green;
    rgb_if.blue  <= px.blue;
    do @(posedge clk); while (!rgb_if.ready);
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    rgb_if.valid <= 1'b0;
    do @(negedge clk); while (pending_hsv.size() != 0);
  endtask

  function automatic logic [7:0] near_level(int base);
    int v;
    v = base + $urandom_range(0, 6) - 3;
    if (v < 0) v = 0;
    if (v > CH_MAX) v = CH_MAX;
    return v[7:0];
  endfunction

  task automatic test_corners();
    rgb_t corners[$] = '{
      '{8'd0,   8'd0,   8'd0},   '{8'd255, 8'd255, 8'd255}, '{8'd128, 8'd128, 8'd128},
      '{8'd1,   8'd1,   8'd1},   '{8'd255, 8'd0,   8'd0},   '{8'd0,   8'd255, 8'd0},
      '{8'd0,   8'd0,   8'd255}, '{8'd255, 8'd255, 8'd0},   '{8'd0,   8'd255, 8'd255},
      '{8'd255, 8'd0,   8'd255}, '{8'd255, 8'd0,   8'd1},   '{8'd255, 8'd1,   8'd0},
      '{8'd1,   8'd0,   8'd0},   '{8'd0,   8'd1,   8'd0},   '{8'd0,   8'd0,   8'd1},
      '{8'd255, 8'd254, 8'd0},   '{8'd0,   8'd255, 8'd254}, '{8'd254, 8'd0,   8'd255},
      '{8'd170, 8'd85,  8'd85},  '{8'd85,  8'd170, 8'd170}, '{8'd255, 8'd127, 8'd128},
      '{8'd128, 8'd0,   8'd255}
    };
    foreach (corners[i]) send_pixel(corners[i]);
  endtask

  task automatic test_uniform(input int n);
    rgb_t px;
    repeat (n) begin
      px = '{red: $urandom, green: $urandom, blue: $urandom};
      send_pixel(px);
    end
  endtask

  // gray pixels and tied max or min channels
  task automatic test_ties(input int n);
    rgb_t px;
    logic [7:0] a, b;
    repeat (n) begin
      a = $urandom;
      b = $urandom;
      case ($urandom_range(0, 3))
        0: px = '{red: a, green: a, blue: a};
        1: px = '{red: a, green: a, blue: b};
        2: px = '{red: b, green: a, blue: a};
        default: px = '{red: a, green: b, blue: a};
      endcase
      send_pixel(px);
    end
  endtask

  task automatic test_small_delta(input int n);
    rgb_t px;
    int base;
    repeat (n) begin
      base = $urandom_range(0, CH_MAX);
      px = '{red: near_level(base), green: near_level(base), blue: near_level(base)};
      send_pixel(px);
    end
  endtask

  task automatic test_back_to_back(input int n);
    source_gaps = 1'b0;
    sink_stalls = 1'b0;
    test_uniform(n);
    source_gaps = 1'b1;
    sink_stalls = 1'b1;
  endtask

  task automatic test_drained_bursts(input int bursts, input int len);
    repeat (bursts) begin
      wait_for_drain();
      test_uniform(len);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    rgb_if.valid = 1'b0;
    rgb_if.red = '0;
    rgb_if.green = '0;
    rgb_if.blue = '0;
    hsv_if.ready = 1'b0;
    mismatch_count = 0;
    pixels_taken = 0;
    gray_seen = 0;
    wrapped_seen = 0;
    cycle_count = 0;
    source_gaps = 1'b1;
    sink_stalls = 1'b1;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_corners();
    test_uniform(300);
    test_ties(150);
    test_small_delta(150);
    test_back_to_back(100);
    test_drained_bursts(5, 20);

    wait_for_drain();
    repeat (FLUSH_WAIT) @(negedge clk);

    $display("converted %0d pixels: %0d gray, %0d in the wrapping red sector",
             pixels_taken, gray_seen, wrapped_seen);
    $display("source gaps, sink stalls, back-to-back and drained bursts, %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0 && pending_hsv.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== rgb_to_hsv_pixel.f =====
+incdir+sv
sv/rhsv_pkg.sv
sv/rhsv_if.sv
sv/rhsv_front.sv
sv/rhsv_div.sv
sv/rhsv_back.sv
sv/rgb_to_hsv_pixel.sv
dv/tb.sv
